/* rtl/core/ell_pkg.sv */
// Shared types, constants and command codes for the extent list entry locator.
package ell_pkg;

    localparam int MAX_EXTENTS  = 16;
    localparam int RECORD_BYTES = 1024;

    localparam int IDX_W   = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int COUNT_W = $clog2(MAX_EXTENTS + 1);
    localparam int REC_W   = $clog2(RECORD_BYTES + 1);
    localparam int OFS_W   = 32 + REC_W;

    localparam int CMD_W   = 2;
    localparam int EXT_W   = 48;
    localparam int INDEX_W = 32;
    localparam int CB_W    = 22;
    localparam int ADDR_W  = 64;
    localparam int STAT_W  = 2;
    localparam int HALF_W  = EXT_W / 2;
    localparam int PROD_W  = HALF_W + CB_W;

    localparam logic [CB_W-1:0] CB_RESET = CB_W'(4096);

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [IDX_W-1:0]   t_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR     = 2'd0,
        CMD_APPEND    = 2'd1,
        CMD_TRANSLATE = 2'd2
    } t_cmd_code;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status_code;

    typedef enum logic [2:0] {
        RES_OK_ZERO,
        RES_FULL,
        RES_MISS_EMPTY,
        RES_HIT,
        RES_MISS
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     clear;
        logic     append;
        logic     tr_init;
        logic     rd_first;
        logic     rd_next;
        logic     mul_lo;
        logic     mul_hi;
        logic     sum;
        logic     step;
        logic     res_set;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             hit;
        logic             last;
    } t_dp_stat;

endpackage

/* rtl/core/ell_dp.sv */
// Datapath: extent store, offset walk arithmetic, result and output registers.
module ell_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ell_pkg::t_dp_ctl        i_ctl,
    output ell_pkg::t_dp_stat       o_stat,
    input  logic                    i_cfg_valid,
    input  logic [ell_pkg::CB_W-1:0]    i_cfg_data,
    input  logic [ell_pkg::CMD_W-1:0]   i_command,
    input  logic [ell_pkg::EXT_W-1:0]   i_extent_start,
    input  logic [ell_pkg::EXT_W-1:0]   i_extent_length,
    input  logic [ell_pkg::INDEX_W-1:0] i_record_index,
    output logic [ell_pkg::ADDR_W-1:0]  o_byte_address,
    output logic [ell_pkg::STAT_W-1:0]  o_status
);
    import ell_pkg::*;

    logic [EXT_W-1:0]   r_mem_start [MAX_EXTENTS];
    logic [EXT_W-1:0]   r_mem_len   [MAX_EXTENTS];

    logic [CMD_W-1:0]   r_cmd;
    logic [EXT_W-1:0]   r_start_in;
    logic [EXT_W-1:0]   r_len_in;
    logic [INDEX_W-1:0] r_index;
    logic [CB_W-1:0]    r_cluster_bytes;
    t_count             r_count;
    t_idx               r_idx;
    t_idx               rd_addr;
    logic [EXT_W-1:0]   r_rd_start;
    logic [EXT_W-1:0]   r_rd_len;
    logic [PROD_W-1:0]  r_ps_lo;
    logic [PROD_W-1:0]  r_pl_lo;
    logic [PROD_W-1:0]  r_ps_hi;
    logic [PROD_W-1:0]  r_pl_hi;
    logic [ADDR_W-1:0]  r_span;
    logic [ADDR_W-1:0]  r_start_byte;
    logic [ADDR_W-1:0]  r_offset;
    logic [ADDR_W-1:0]  r_res_addr;
    logic [STAT_W-1:0]  r_res_status;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [STAT_W-1:0]  r_o_status;
    logic [OFS_W-1:0]   ofs_prod;
    logic [ADDR_W-1:0]  n_res_addr;
    logic [STAT_W-1:0]  n_res_status;

    assign ofs_prod = OFS_W'(r_index) * OFS_W'(RECORD_BYTES);
    assign rd_addr  = i_ctl.rd_first ? '0 : t_idx'(r_idx + 1'b1);

    assign o_stat.cmd   = r_cmd;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == COUNT_W'(MAX_EXTENTS));
    assign o_stat.hit   = (r_offset < r_span);
    assign o_stat.last  = ((t_count'(r_idx) + t_count'(1)) == r_count);

    always_comb begin
        case (i_ctl.res_sel)
            RES_FULL: begin
                n_res_addr   = '0;
                n_res_status = ST_FULL;
            end
            RES_MISS_EMPTY: begin
                n_res_addr   = '0;
                n_res_status = ST_MISS;
            end
            RES_HIT: begin
                n_res_addr   = r_start_byte + r_offset;
                n_res_status = ST_OK;
            end
            RES_MISS: begin
                n_res_addr   = r_start_byte;
                n_res_status = ST_MISS;
            end
            default: begin
                n_res_addr   = '0;
                n_res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_cluster_bytes <= CB_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_cluster_bytes <= i_cfg_data;
            end
            if (i_ctl.clear) begin
                r_count <= '0;
            end else if (i_ctl.append) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.append) begin
            r_mem_start[r_count[IDX_W-1:0]] <= r_start_in;
            r_mem_len[r_count[IDX_W-1:0]]   <= r_len_in;
        end
        if (i_ctl.rd_first || i_ctl.rd_next) begin
            r_rd_start <= r_mem_start[rd_addr];
            r_rd_len   <= r_mem_len[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd      <= i_command;
            r_start_in <= i_extent_start;
            r_len_in   <= i_extent_length;
            r_index    <= i_record_index;
        end
        if (i_ctl.tr_init) begin
            r_offset     <= ADDR_W'(ofs_prod);
            r_idx        <= '0;
            r_start_byte <= '0;
        end else if (i_ctl.step) begin
            r_offset <= r_offset - r_span;
            r_idx    <= r_idx + 1'b1;
        end
        if (i_ctl.mul_lo) begin
            r_ps_lo <= PROD_W'(r_rd_start[HALF_W-1:0]) * PROD_W'(r_cluster_bytes);
            r_pl_lo <= PROD_W'(r_rd_len[HALF_W-1:0]) * PROD_W'(r_cluster_bytes);
        end
        if (i_ctl.mul_hi) begin
            r_ps_hi <= PROD_W'(r_rd_start[EXT_W-1:HALF_W]) * PROD_W'(r_cluster_bytes);
            r_pl_hi <= PROD_W'(r_rd_len[EXT_W-1:HALF_W]) * PROD_W'(r_cluster_bytes);
        end
        if (i_ctl.sum) begin
            r_span       <= ADDR_W'(r_pl_lo) + {r_pl_hi[ADDR_W-HALF_W-1:0], HALF_W'(0)};
            r_start_byte <= ADDR_W'(r_ps_lo) + {r_ps_hi[ADDR_W-HALF_W-1:0], HALF_W'(0)};
        end
        if (i_ctl.res_set) begin
            r_res_addr   <= n_res_addr;
            r_res_status <= n_res_status;
        end
        if (i_ctl.out_load) begin
            r_o_addr   <= r_res_addr;
            r_o_status <= r_res_status;
        end
    end

    assign o_byte_address = r_o_addr;
    assign o_status       = r_o_status;

endmodule

/* rtl/core/ell_ctrl.sv */
// Controller: command sequencing, extent walk control and output valid.
module ell_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  ell_pkg::t_dp_stat i_stat,
    output ell_pkg::t_dp_ctl  o_ctl
);
    import ell_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_CMP,
        S_EMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    out_free;
    t_dp_ctl ctl;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        ctl     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    ctl.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                ctl.res_set = 1'b1;
                ctl.res_sel = RES_OK_ZERO;
                n_state     = S_EMIT;
                case (i_stat.cmd)
                    CMD_CLEAR: begin
                        ctl.clear = 1'b1;
                    end
                    CMD_APPEND: begin
                        if (i_stat.full) begin
                            ctl.res_sel = RES_FULL;
                        end else begin
                            ctl.append = 1'b1;
                        end
                    end
                    CMD_TRANSLATE: begin
                        if (i_stat.empty) begin
                            ctl.res_sel = RES_MISS_EMPTY;
                        end else begin
                            ctl.res_set  = 1'b0;
                            ctl.tr_init  = 1'b1;
                            ctl.rd_first = 1'b1;
                            n_state      = S_MUL_LO;
                        end
                    end
                    default: begin
                        ctl.res_sel = RES_OK_ZERO;
                    end
                endcase
            end
            S_MUL_LO: begin
                ctl.mul_lo = 1'b1;
                n_state    = S_MUL_HI;
            end
            S_MUL_HI: begin
                ctl.mul_hi = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                ctl.sum = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.hit) begin
                    ctl.res_set = 1'b1;
                    ctl.res_sel = RES_HIT;
                    n_state     = S_EMIT;
                end else begin
                    ctl.step = 1'b1;
                    if (i_stat.last) begin
                        ctl.res_set = 1'b1;
                        ctl.res_sel = RES_MISS;
                        n_state     = S_EMIT;
                    end else begin
                        ctl.rd_next = 1'b1;
                        n_state     = S_MUL_LO;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ctl   = ctl;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

/* rtl/core/extent_list_entry_locator.sv */
// Top level of the extent list entry locator: controller and datapath.
//
//  Channel  Direction  Handshake                Payload
//  input    in         i_valid / o_stall        i_command, i_extent_start,
//                                               i_extent_length, i_record_index
//  output   out        o_valid / i_stall        o_byte_address, o_status
//  config   in         i_cfg_valid / o_cfg_ready  i_cfg_data (cluster_bytes)
//
// One transaction is taken at a time. For clear, append, the unused command and a
// translation on an empty table, the command is decoded in S_DECODE and the result
// is loaded into the output register from S_EMIT, and o_valid rises with that load
// once the output register is free. A translation visits up to 16 extents, and for
// each one it passes S_MUL_LO, S_MUL_HI, S_SUM and S_CMP: two multiply halves, the sum and the compare.
// The input is free again on the edge that loads the result. Reset is synchronous and
// empties the table and sets cluster_bytes to 4096. A finished result waits in the
// output register under i_stall while the next transaction is accepted and worked on.
module extent_list_entry_locator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ell_pkg::CMD_W-1:0]   i_command,
    input  logic [ell_pkg::EXT_W-1:0]   i_extent_start,
    input  logic [ell_pkg::EXT_W-1:0]   i_extent_length,
    input  logic [ell_pkg::INDEX_W-1:0] i_record_index,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ell_pkg::ADDR_W-1:0]  o_byte_address,
    output logic [ell_pkg::STAT_W-1:0]  o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ell_pkg::CB_W-1:0]    i_cfg_data
);
    import ell_pkg::*;

    t_dp_ctl  ctl;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    ell_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    ell_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_extent_start  (i_extent_start),
        .i_extent_length (i_extent_length),
        .i_record_index  (i_record_index),
        .o_byte_address  (o_byte_address),
        .o_status        (o_status)
    );

endmodule
